>>> rtl/core/dlbf_pkg.sv
// Package for the depth left-border finder: sizes, register codes, shared types.
`default_nettype none
package dlbf_pkg;

  localparam int COLS   = 480;
  localparam int ROWS   = 640;
  localparam int WINDOW = 100;

  localparam int DEPTH_W = 16;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int NEED_W  = 7;
  localparam int CMP_W   = (CNT_W > NEED_W) ? CNT_W : NEED_W;

  // candidates judged at row end: cells WINDOW-1 down to 2
  localparam int NC     = WINDOW - 2;
  localparam int GRP    = 8;
  localparam int OFF_W  = 3;
  localparam int NG     = (NC + GRP - 1) / GRP;
  localparam int GSEL_W = (NG > 1) ? $clog2(NG) : 1;
  localparam int POS_W  = $clog2(WINDOW);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_LIMIT = 3'd0,
    REG_EDGE_STEP    = 3'd1,
    REG_NEAR_FLOOR   = 3'd2,
    REG_FAR_CEILING  = 3'd3,
    REG_WINDOW_FLOOR = 3'd4,
    REG_COUNT_NEEDED = 3'd5,
    REG_START_COLUMN = 3'd6
  } cfg_reg_e;

  localparam logic [COL_W-1:0]   RST_COLUMN_LIMIT = 9'd285;
  localparam logic [DEPTH_W-1:0] RST_EDGE_STEP    = 16'd500;
  localparam logic [DEPTH_W-1:0] RST_NEAR_FLOOR   = 16'd2000;
  localparam logic [DEPTH_W-1:0] RST_FAR_CEILING  = 16'd3600;
  localparam logic [DEPTH_W-1:0] RST_WINDOW_FLOOR = 16'd1000;
  localparam logic [NEED_W-1:0]  RST_COUNT_NEEDED = 7'd97;
  localparam logic [COL_W-1:0]   RST_START_COLUMN = 9'd300;

  localparam logic [COL_W:0] BORDER_OFFSET = 10'd4;

  typedef struct packed {
    logic [COL_W-1:0]   column_limit;
    logic [DEPTH_W-1:0] edge_step;
    logic [DEPTH_W-1:0] near_floor;
    logic [DEPTH_W-1:0] far_ceiling;
    logic [DEPTH_W-1:0] window_floor;
    logic [NEED_W-1:0]  count_needed;
    logic [COL_W-1:0]   start_column;
  } cfg_t;

  // per-item token that travels beside the cell row
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_end;
    logic             frame_end;
  } tok_t;

  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/dlbf_cell.sv
// One cell of the pixel row: holds a depth and its running in-range count, tests its edge.
`default_nettype none
module dlbf_cell (
  input  wire logic                        clk,
  input  wire logic                        shift,
  input  wire logic [dlbf_pkg::DEPTH_W-1:0] depth_in,
  input  wire logic [dlbf_pkg::CNT_W-1:0]   cnt_in,
  input  wire logic                        add_bit,
  input  wire logic [dlbf_pkg::DEPTH_W-1:0] partner_depth,
  input  wire dlbf_pkg::cfg_t              cfg,
  output logic      [dlbf_pkg::DEPTH_W-1:0] depth,
  output logic      [dlbf_pkg::CNT_W-1:0]   cnt,
  output logic                             hit
);

  logic [dlbf_pkg::DEPTH_W:0] drop_ref;
  logic                       edge_ok;
  logic                       band_ok;
  logic                       count_ok;

  // count = in-range pixels from this cell's column up to the newest one
  always_ff @(posedge clk) begin
    if (shift) begin
      depth <= depth_in;
      cnt   <= cnt_in + dlbf_pkg::CNT_W'(add_bit);
    end
  end

  always_comb begin
    drop_ref = {1'b0, partner_depth} + {1'b0, cfg.edge_step};
    edge_ok  = {1'b0, depth} > drop_ref;
    band_ok  = (depth > cfg.near_floor) && (partner_depth > cfg.near_floor) &&
               (depth < cfg.far_ceiling) && (partner_depth < cfg.far_ceiling);
    count_ok = dlbf_pkg::CMP_W'(cnt) > dlbf_pkg::CMP_W'(cfg.count_needed);
    hit      = edge_ok && band_ok && count_ok;
  end

endmodule
`default_nettype wire

>>> rtl/core/dlbf_pick.sv
// Picks the first qualifying candidate of an item and keeps the per-frame border state.
`default_nettype none
module dlbf_pick (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dlbf_pkg::tok_t             tok_in,
  input  wire logic [dlbf_pkg::NC-1:0]    qual,
  input  wire logic [dlbf_pkg::COL_W-1:0] start_column,
  output logic                            push,
  output dlbf_pkg::res_t                  result
);

  dlbf_pkg::tok_t                   tok2;
  logic [dlbf_pkg::NG-1:0]          grp_any;
  logic [dlbf_pkg::OFF_W-1:0]       grp_off [dlbf_pkg::NG];
  logic [dlbf_pkg::NG-1:0]          grp_any_next;
  logic [dlbf_pkg::OFF_W-1:0]       grp_off_next [dlbf_pkg::NG];

  logic [dlbf_pkg::COL_W-1:0]       best_column;
  logic [dlbf_pkg::ROW_W-1:0]       best_row;
  logic                             row_done;
  logic                             found;

  logic                             any_sel;
  logic [dlbf_pkg::GSEL_W-1:0]      g_sel;
  logic [dlbf_pkg::POS_W-1:0]       pos;
  logic [dlbf_pkg::COL_W:0]         cand;
  logic                             take;
  logic [dlbf_pkg::COL_W-1:0]       best_column_next;
  logic [dlbf_pkg::ROW_W-1:0]       best_row_next;
  logic                             found_next;
  logic                             row_done_next;

  // stage 2: first set bit inside each group of eight
  always_comb begin
    for (int g = 0; g < dlbf_pkg::NG; g++) begin
      grp_any_next[g] = 1'b0;
      grp_off_next[g] = '0;
      for (int b = dlbf_pkg::GRP - 1; b >= 0; b--) begin
        if ((g * dlbf_pkg::GRP + b) < dlbf_pkg::NC) begin
          if (qual[g * dlbf_pkg::GRP + b]) begin
            grp_any_next[g] = 1'b1;
            grp_off_next[g] = dlbf_pkg::OFF_W'(b);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok2    <= '0;
      grp_any <= '0;
    end else begin
      tok2    <= tok_in;
      grp_any <= grp_any_next;
    end
  end

  always_ff @(posedge clk) begin
    grp_off <= grp_off_next;
  end

  // stage 3: first group, then the border update
  always_comb begin
    any_sel = 1'b0;
    g_sel   = '0;
    for (int g = dlbf_pkg::NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        any_sel = 1'b1;
        g_sel   = dlbf_pkg::GSEL_W'(g);
      end
    end
    pos  = dlbf_pkg::POS_W'({g_sel, grp_off[g_sel]});
    // j = col - (WINDOW-1) + pos; border is j + 4
    cand = {1'b0, tok2.col} - (dlbf_pkg::COL_W + 1)'(dlbf_pkg::WINDOW - 1) +
           (dlbf_pkg::COL_W + 1)'(pos) + dlbf_pkg::BORDER_OFFSET;
    take = tok2.valid && any_sel && !row_done && (cand < {1'b0, best_column});

    best_column_next = take ? cand[dlbf_pkg::COL_W-1:0] : best_column;
    best_row_next    = take ? tok2.row : best_row;
    found_next       = take || found;
    row_done_next    = (take || row_done) && !tok2.row_end;

    push          = tok2.valid && tok2.frame_end;
    result.column = best_column_next;
    result.row    = best_row_next;
    result.found  = found_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_column <= dlbf_pkg::RST_START_COLUMN;
      best_row    <= '0;
      found       <= 1'b0;
      row_done    <= 1'b0;
    end else if (tok2.valid) begin
      if (tok2.frame_end) begin
        best_column <= start_column;
        best_row    <= '0;
        found       <= 1'b0;
        row_done    <= 1'b0;
      end else begin
        best_column <= best_column_next;
        best_row    <= best_row_next;
        found       <= found_next;
        row_done    <= row_done_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dlbf_result_fifo.sv
// Small result queue between the border logic and the output stream.
`default_nettype none
module dlbf_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dlbf_pkg::res_t push_data,
  input  wire logic           pop,
  output logic                out_valid,
  output dlbf_pkg::res_t      out_data
);

  dlbf_pkg::res_t                mem [dlbf_pkg::FIFO_DEPTH];
  logic [dlbf_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [dlbf_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [dlbf_pkg::FIFO_AW:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

endmodule
`default_nettype wire

>>> rtl/core/depth_left_border_finder.sv
// Top level of the depth left-border finder: config registers, cell row, picker, result queue.
// Throughput: one pixel per cycle unless stalled; the cell row shifts one column per accepted item.
// A frame's last pixel passes tok0, tok1 and tok2 before its result is pushed into the result queue.
// Row-end candidates are tested in parallel across the cells, then resolved in two stages.
// Input stalls only while 8 frame results are outstanding, in flight or in the result queue.
// Reset (rst, synchronous): counters, border state and queue clear; registers take defaults.
`default_nettype none
module depth_left_border_finder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,   // [15:0] depth
  input  wire logic                            s_axis_tlast,   // frame_end
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [23:0]                     m_axis_tdata,   // [8:0] border_column, [18:9] border_row
  output logic      [0:0]                      m_axis_tuser,   // [0] found
  input  wire logic                            cfg_write,
  input  wire logic [dlbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dlbf_pkg::CFG_DATA_W-1:0] cfg_data
);

  dlbf_pkg::cfg_t                   cfg;
  logic                             accept;
  logic [dlbf_pkg::DEPTH_W-1:0]     new_depth;
  logic                             new_range;

  logic [dlbf_pkg::COL_W-1:0]       col;
  logic [dlbf_pkg::ROW_W-1:0]       row;
  logic                             at_row_end;
  dlbf_pkg::tok_t                   tok0;
  dlbf_pkg::tok_t                   tok1;

  logic [dlbf_pkg::DEPTH_W-1:0]     cell_depth [dlbf_pkg::WINDOW];
  logic [dlbf_pkg::CNT_W-1:0]       cell_cnt   [dlbf_pkg::WINDOW];
  logic [dlbf_pkg::WINDOW-1:0]      cell_hit;

  logic [dlbf_pkg::NC-1:0]          qual_next;
  logic [dlbf_pkg::NC-1:0]          qual;

  logic                             push;
  dlbf_pkg::res_t                   push_data;
  dlbf_pkg::res_t                   head;
  logic                             out_accept;
  logic [dlbf_pkg::FIFO_AW:0]       reserved;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_limit <= dlbf_pkg::RST_COLUMN_LIMIT;
      cfg.edge_step    <= dlbf_pkg::RST_EDGE_STEP;
      cfg.near_floor   <= dlbf_pkg::RST_NEAR_FLOOR;
      cfg.far_ceiling  <= dlbf_pkg::RST_FAR_CEILING;
      cfg.window_floor <= dlbf_pkg::RST_WINDOW_FLOOR;
      cfg.count_needed <= dlbf_pkg::RST_COUNT_NEEDED;
      cfg.start_column <= dlbf_pkg::RST_START_COLUMN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dlbf_pkg::REG_COLUMN_LIMIT: cfg.column_limit <= cfg_data[dlbf_pkg::COL_W-1:0];
        dlbf_pkg::REG_EDGE_STEP:    cfg.edge_step    <= cfg_data;
        dlbf_pkg::REG_NEAR_FLOOR:   cfg.near_floor   <= cfg_data;
        dlbf_pkg::REG_FAR_CEILING:  cfg.far_ceiling  <= cfg_data;
        dlbf_pkg::REG_WINDOW_FLOOR: cfg.window_floor <= cfg_data;
        dlbf_pkg::REG_COUNT_NEEDED: cfg.count_needed <= cfg_data[dlbf_pkg::NEED_W-1:0];
        dlbf_pkg::REG_START_COLUMN: cfg.start_column <= cfg_data[dlbf_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign new_depth  = s_axis_tdata;
  assign new_range  = (new_depth > cfg.window_floor) && (new_depth < cfg.far_ceiling);
  assign at_row_end = (col == dlbf_pkg::COL_W'(dlbf_pkg::COLS - 1));

  // column / row position of the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        col <= '0;
        row <= '0;
      end else if (at_row_end) begin
        col <= '0;
        row <= (row == dlbf_pkg::ROW_W'(dlbf_pkg::ROWS - 1)) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok0 <= '0;
    end else begin
      tok0.valid     <= accept;
      tok0.col       <= col;
      tok0.row       <= row;
      tok0.row_end   <= at_row_end;
      tok0.frame_end <= s_axis_tlast;
    end
  end

  // cell k holds the pixel k columns behind the newest one
  for (genvar k = 0; k < dlbf_pkg::WINDOW; k++) begin : g_cell
    logic [dlbf_pkg::DEPTH_W-1:0] d_in;
    logic [dlbf_pkg::CNT_W-1:0]   c_in;
    logic [dlbf_pkg::DEPTH_W-1:0] partner;

    if (k == 0) begin : g_head
      assign d_in = new_depth;
      assign c_in = '0;
    end else begin : g_body
      assign d_in = cell_depth[k-1];
      assign c_in = cell_cnt[k-1];
    end

    if (k >= 2) begin : g_partner
      assign partner = cell_depth[k-2];
    end else begin : g_no_partner
      assign partner = '0;
    end

    dlbf_cell u_cell (
      .clk           (clk),
      .shift         (accept),
      .depth_in      (d_in),
      .cnt_in        (c_in),
      .add_bit       (new_range),
      .partner_depth (partner),
      .cfg           (cfg),
      .depth         (cell_depth[k]),
      .cnt           (cell_cnt[k]),
      .hit           (cell_hit[k])
    );
  end

  // candidate p sits in cell WINDOW-1-p; only the oldest cell is judged mid-row
  always_comb begin
    for (int p = 0; p < dlbf_pkg::NC; p++) begin
      logic [dlbf_pkg::COL_W-1:0] j;
      logic                       en;
      j  = tok0.col - dlbf_pkg::COL_W'(dlbf_pkg::WINDOW - 1 - p);
      en = (p == 0) ? (tok0.col >= dlbf_pkg::COL_W'(dlbf_pkg::WINDOW - 1)) : tok0.row_end;
      qual_next[p] = tok0.valid && en && cell_hit[dlbf_pkg::WINDOW - 1 - p] &&
                     (j < cfg.column_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1 <= '0;
      qual <= '0;
    end else begin
      tok1 <= tok0;
      qual <= qual_next;
    end
  end

  dlbf_pick u_pick (
    .clk          (clk),
    .rst          (rst),
    .tok_in       (tok1),
    .qual         (qual),
    .start_column (cfg.start_column),
    .push         (push),
    .result       (push_data)
  );

  assign out_accept = m_axis_tvalid && m_axis_tready;

  dlbf_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (out_accept),
    .out_valid (m_axis_tvalid),
    .out_data  (head)
  );

  // queue slots reserved by frame ends still in flight or waiting
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if ((accept && s_axis_tlast) && !out_accept) begin
      reserved <= reserved + 1'b1;
    end else if (out_accept && !(accept && s_axis_tlast)) begin
      reserved <= reserved - 1'b1;
    end
  end

  assign s_axis_tready = (reserved < (dlbf_pkg::FIFO_AW + 1)'(dlbf_pkg::FIFO_DEPTH));

  assign m_axis_tdata = {5'b0, head.row, head.column};
  assign m_axis_tuser = head.found;

endmodule
`default_nettype wire

>>> rtl/core/dlbf_checker.sv
// Port-level checks for the depth left-border finder, bound to the top level.
`default_nettype none
module dlbf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  logic in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("waiting result changed");

  // no border found means row zero
  a_row_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[18:9] == 10'd0)
    else $error("row set without a border");

  // an accepted border is a column plus four
  a_col_min: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[8:0] >= 9'd4)
    else $error("border column below four");

  // an empty queue only fills from an earlier accepted frame end
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid ##1 m_axis_tvalid |-> $past(in_accept && s_axis_tlast, 4))
    else $error("result without a frame end");

endmodule

bind depth_left_border_finder dlbf_checker u_dlbf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
